// ===== src/arip_pkg.sv =====
// Shared widths, register codes and item types for the affine reprojection inlier counter.
`default_nettype none
package arip_pkg;

  // Field widths.
  localparam int COORD_W = 20;
  localparam int COEF_W  = 24;
  localparam int RAD_W   = 16;
  localparam int DIST_W  = 48;
  localparam int TOTAL_W = 17;

  // Inlier count saturation point and the counter width it needs.
  localparam int MAX_POINTS = 65536;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Datapath widths.
  localparam int PROD_W = COEF_W + COORD_W;      // one coefficient times one coordinate
  localparam int ACC_W  = PROD_W + 2;            // two products plus shifted translation
  localparam int FRAC_W = 16;                    // Q8.16 fraction bits
  localparam int PROJ_W = ACC_W - FRAC_W;        // projected coordinate, 1/16 px
  localparam int RES_W  = PROJ_W + 1;            // residual after subtracting dst
  localparam int MAG_W  = RES_W - 1;             // residual magnitude
  localparam int SQ_W   = 2 * MAG_W;             // squared magnitude
  localparam int SUM_W  = SQ_W + 1;              // sum of both squares
  localparam int RSQ_W  = 2 * RAD_W;             // squared radius

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Front pipeline depth, used for the credit check on the input.
  localparam int FRONT_STAGES = 2;
  localparam int FCNT_W       = $clog2(FRONT_STAGES + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX       = 3'd0,
    REG_COEF_XY       = 3'd1,
    REG_SHIFT_X       = 3'd2,
    REG_COEF_YX       = 3'd3,
    REG_COEF_YY       = 3'd4,
    REG_SHIFT_Y       = 3'd5,
    REG_INLIER_RADIUS = 3'd6
  } reg_index_t;

  // Register reset values.
  localparam logic signed [COEF_W-1:0] COEF_ONE     = 24'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_ZERO    = 24'sd0;
  localparam logic        [RAD_W-1:0]  RADIUS_RESET = 16'd48;

  // Affine model and threshold as held in the register file.
  typedef struct packed {
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] shift_x;
    logic signed [COEF_W-1:0] coef_yx;
    logic signed [COEF_W-1:0] coef_yy;
    logic signed [COEF_W-1:0] shift_y;
    logic        [RAD_W-1:0]  inlier_radius;
  } cfg_t;

  // One input correspondence.
  typedef struct packed {
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] dst_x;
    logic signed [COORD_W-1:0] dst_y;
    logic                      last_pair;
  } point_t;

  // Residual pair passed from front to back.
  typedef struct packed {
    logic signed [RES_W-1:0] err_x;
    logic signed [RES_W-1:0] err_y;
    logic                    last_pair;
  } resid_t;

endpackage
`default_nettype wire

// ===== src/arip_front.sv =====
// Front end: multiplies the source point by the affine model and forms the residuals.
`default_nettype none
module arip_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire arip_pkg::cfg_t    cfg,
  input  wire logic              in_take,
  input  wire arip_pkg::point_t  in_item,
  output logic [arip_pkg::FCNT_W-1:0] in_flight,
  output logic                   push,
  output arip_pkg::resid_t       push_item
);

  // Stage one: the four linear products.
  logic                                  v1;
  logic signed [arip_pkg::PROD_W-1:0]    p_xx, p_xy, p_yx, p_yy;
  logic signed [arip_pkg::COORD_W-1:0]   d_x, d_y;
  logic                                  last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    p_xx  <= cfg.coef_xx * in_item.src_x;
    p_xy  <= cfg.coef_xy * in_item.src_y;
    p_yx  <= cfg.coef_yx * in_item.src_x;
    p_yy  <= cfg.coef_yy * in_item.src_y;
    d_x   <= in_item.dst_x;
    d_y   <= in_item.dst_y;
    last1 <= in_item.last_pair;
  end

  // Stage two: add translation, round half up to 1/16 px, subtract destination.
  localparam logic signed [arip_pkg::ACC_W-1:0] ROUND_HALF =
    arip_pkg::ACC_W'(1) <<< (arip_pkg::FRAC_W - 1);

  logic signed [arip_pkg::ACC_W-1:0]  acc_x, acc_y;
  logic signed [arip_pkg::PROJ_W-1:0] proj_x, proj_y;

  always_comb begin
    acc_x = arip_pkg::ACC_W'(p_xx) + arip_pkg::ACC_W'(p_xy)
          + (arip_pkg::ACC_W'(cfg.shift_x) <<< arip_pkg::FRAC_W) + ROUND_HALF;
    acc_y = arip_pkg::ACC_W'(p_yx) + arip_pkg::ACC_W'(p_yy)
          + (arip_pkg::ACC_W'(cfg.shift_y) <<< arip_pkg::FRAC_W) + ROUND_HALF;
    // An arithmetic drop of the fraction bits is the floor.
    proj_x = $signed(acc_x[arip_pkg::ACC_W-1:arip_pkg::FRAC_W]);
    proj_y = $signed(acc_y[arip_pkg::ACC_W-1:arip_pkg::FRAC_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= v1;
    end
  end

  always_ff @(posedge clk) begin
    push_item.err_x     <= arip_pkg::RES_W'(proj_x) - arip_pkg::RES_W'(d_x);
    push_item.err_y     <= arip_pkg::RES_W'(proj_y) - arip_pkg::RES_W'(d_y);
    push_item.last_pair <= last1;
  end

  // Requests still inside the front, not yet in the queue.
  assign in_flight = arip_pkg::FCNT_W'(v1) + arip_pkg::FCNT_W'(push);

endmodule
`default_nettype wire

// ===== src/arip_fifo.sv =====
// Short queue of residual pairs between the front and back ends.
`default_nettype none
module arip_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire arip_pkg::resid_t   push_item,
  input  wire logic               pop,
  output arip_pkg::resid_t        head,
  output logic                    not_empty,
  output logic [arip_pkg::QCNT_W-1:0] count
);

  arip_pkg::resid_t              slots [arip_pkg::QDEPTH];
  logic [arip_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + arip_pkg::QCNT_W'(push) - arip_pkg::QCNT_W'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

`ifndef ASSERT_OFF
  // The input credit check must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < arip_pkg::QCNT_W'(arip_pkg::QDEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

// ===== src/arip_back.sv =====
// Back end: squares the residuals, tests against the radius and keeps the inlier count.
`default_nettype none
module arip_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [arip_pkg::RAD_W-1:0] inlier_radius,
  input  wire arip_pkg::resid_t   head,
  input  wire logic               not_empty,
  output logic                    pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic                    out_inlier,
  output logic [arip_pkg::DIST_W-1:0]  out_dist,
  output logic [arip_pkg::TOTAL_W-1:0] out_total,
  output logic                    out_last
);

  localparam logic [arip_pkg::CNT_W-1:0] CNT_MAX = arip_pkg::CNT_W'(arip_pkg::MAX_POINTS);

  // Squared radius; user keeps register file steady with items in flight, unchecked.
  logic [arip_pkg::RSQ_W-1:0] rsq;
  always_ff @(posedge clk) begin
    rsq <= inlier_radius * inlier_radius;
  end

  // Handshake between the square stage and the output register.
  logic v1;
  logic out_ready, b1_ready, advance;

  assign out_ready = !m_tvalid || m_tready;
  assign b1_ready  = !v1 || out_ready;
  assign pop       = not_empty && b1_ready;
  assign advance   = v1 && out_ready;

  // Square stage: magnitudes and their squares.
  logic [arip_pkg::MAG_W-1:0] mag_x, mag_y;
  logic [arip_pkg::SQ_W-1:0]  sq_x, sq_y;
  logic                       last1;

  always_comb begin
    mag_x = head.err_x[arip_pkg::RES_W-1] ? arip_pkg::MAG_W'(-head.err_x)
                                          : arip_pkg::MAG_W'(head.err_x);
    mag_y = head.err_y[arip_pkg::RES_W-1] ? arip_pkg::MAG_W'(-head.err_y)
                                          : arip_pkg::MAG_W'(head.err_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (b1_ready) begin
      v1 <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sq_x  <= mag_x * mag_x;
      sq_y  <= mag_y * mag_y;
      last1 <= head.last_pair;
    end
  end

  // Sum, threshold test, saturation and count update.
  logic [arip_pkg::SUM_W-1:0]  sum;
  logic                        inl;
  logic [arip_pkg::DIST_W-1:0] dist_sat;
  logic [arip_pkg::CNT_W-1:0]  running_count, cnt_after, running_count_next;

  always_comb begin
    sum  = arip_pkg::SUM_W'(sq_x) + arip_pkg::SUM_W'(sq_y);
    inl  = (sum <= arip_pkg::SUM_W'(rsq));
    dist_sat = (|sum[arip_pkg::SUM_W-1:arip_pkg::DIST_W]) ? '1 : sum[arip_pkg::DIST_W-1:0];
    cnt_after = (inl && running_count < CNT_MAX) ? running_count + 1'b1 : running_count;
    running_count_next = last1 ? '0 : cnt_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (advance) running_count <= running_count_next;
      if (out_ready) m_tvalid <= v1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_inlier <= inl;
      out_dist   <= dist_sat;
      out_total  <= arip_pkg::TOTAL_W'(cnt_after);
      out_last   <= last1;
    end
  end

`ifndef ASSERT_OFF
  // A flagged inlier never carries an error above the squared radius.
  a_inlier_dist: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_inlier |-> out_dist <= arip_pkg::DIST_W'(rsq))
    else $error("inlier flag with error above threshold");

  // The count restarts after the last pair of a set.
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    advance && last1 |=> running_count == '0)
    else $error("count not cleared at end of set");
`endif

endmodule
`default_nettype wire

// ===== src/affine_reprojection_inlier_counter.sv =====
// Top level of the affine reprojection inlier counter: register file, front, queue and back.
`default_nettype none
// Each accepted point pair is mapped through the 2x3 affine model in the register file,
// compared with its destination point, and answered by one result carrying the inlier
// flag, the saturated squared error and the running inlier count of the current set;
// the count restarts after a pair marked last. The block takes one pair per cycle when
// the result side keeps up, and each pair passes through two front stages (products,
// then rounding and residual), one entry of the four-deep queue, the squaring stage
// and the output register. The input stops taking pairs when the queue plus the two
// front stages hold four pairs, so a stalled result side backs up into the input.
// Write the registers only while no pair is in flight; the write port is always ready.
module affine_reprojection_inlier_counter (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [arip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [arip_pkg::CFG_DATA_W-1:0] cfg_data,
  // Point pairs.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // src_x[19:0], src_y[39:20], dst_x[59:40], dst_y[79:60]
  input  wire logic        s_tlast,   // last_pair
  // Results.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // dist_sq[47:0], inlier_total[64:48], zero[71:65]
  output logic             m_tuser,   // is_inlier
  output logic             m_tlast    // set_done
);

  arip_pkg::cfg_t cfg;

  // Register file.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_xx       <= arip_pkg::COEF_ONE;
      cfg.coef_xy       <= arip_pkg::COEF_ZERO;
      cfg.shift_x       <= arip_pkg::COEF_ZERO;
      cfg.coef_yx       <= arip_pkg::COEF_ZERO;
      cfg.coef_yy       <= arip_pkg::COEF_ONE;
      cfg.shift_y       <= arip_pkg::COEF_ZERO;
      cfg.inlier_radius <= arip_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        arip_pkg::REG_COEF_XX:       cfg.coef_xx <= cfg_data;
        arip_pkg::REG_COEF_XY:       cfg.coef_xy <= cfg_data;
        arip_pkg::REG_SHIFT_X:       cfg.shift_x <= cfg_data;
        arip_pkg::REG_COEF_YX:       cfg.coef_yx <= cfg_data;
        arip_pkg::REG_COEF_YY:       cfg.coef_yy <= cfg_data;
        arip_pkg::REG_SHIFT_Y:       cfg.shift_y <= cfg_data;
        arip_pkg::REG_INLIER_RADIUS: cfg.inlier_radius <= cfg_data[arip_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input request.
  arip_pkg::point_t in_item;
  assign in_item.src_x     = s_tdata[19:0];
  assign in_item.src_y     = s_tdata[39:20];
  assign in_item.dst_x     = s_tdata[59:40];
  assign in_item.dst_y     = s_tdata[79:60];
  assign in_item.last_pair = s_tlast;

  logic [arip_pkg::FCNT_W-1:0] in_flight;
  logic [arip_pkg::QCNT_W-1:0] q_count;
  logic                        push, pop, not_empty, in_take;
  arip_pkg::resid_t            push_item, head;

  localparam int CREDIT_W = arip_pkg::QCNT_W + 1;

  // Take a pair only if the queue has room for it and every pair ahead of it.
  assign s_tready = (CREDIT_W'(q_count) + CREDIT_W'(in_flight))
                    < CREDIT_W'(arip_pkg::QDEPTH);
  assign in_take  = s_tvalid && s_tready;

  arip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_take   (in_take),
    .in_item   (in_item),
    .in_flight (in_flight),
    .push      (push),
    .push_item (push_item)
  );

  arip_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (q_count)
  );

  logic [arip_pkg::DIST_W-1:0]  out_dist;
  logic [arip_pkg::TOTAL_W-1:0] out_total;

  arip_back u_back (
    .clk           (clk),
    .rst           (rst),
    .inlier_radius (cfg.inlier_radius),
    .head          (head),
    .not_empty     (not_empty),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .out_inlier    (m_tuser),
    .out_dist      (out_dist),
    .out_total     (out_total),
    .out_last      (m_tlast)
  );

  // Pack the result.
  assign m_tdata = {7'd0, out_total, out_dist};

endmodule
`default_nettype wire
